// ----- hw/rtl/brc_pkg.sv -----
`timescale 1ns / 1ps

package brc_pkg;

    localparam logic [63:0] SYSMIS_BITS = 64'hFFEF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SPACES_BITS = 64'h2020_2020_2020_2020;

    localparam logic [7:0] CODE_SYSMIS = 8'd255;
    localparam logic [7:0] CODE_SPACES = 8'd254;
    localparam logic [7:0] CODE_RAW    = 8'd253;
    localparam logic [7:0] CODE_ZERO   = 8'd100;

    localparam logic [7:0] NEG_LIMIT = 8'd99;
    localparam logic [7:0] POS_LIMIT = 8'd151;

    localparam logic [10:0] EXP_BIAS = 11'd1023;
    localparam logic [10:0] EXP_TOP  = 11'd1030;

    localparam logic [30:0] CASE_MAX = 31'h7FFF_FFFF;
    localparam logic [3:0]  OCTET_FULL = 4'd8;

    typedef struct packed {
        logic        octet;
        logic [63:0] cw;
        logic [3:0]  nraw;
        logic        bank;
        logic        tail;
        logic [63:0] tail_word;
        logic        tail_cnt;
    } t_job;

    typedef struct packed {
        logic        en;
        logic [3:0]  addr;
        logic [63:0] data;
    } t_raw_wr;

    typedef struct packed {
        logic en;
        logic bank;
    } t_bank_free;

    function automatic logic [7:0] numeric_code(input logic [63:0] bits);
        logic [10:0] expo;
        logic [51:0] frac;
        logic        neg;
        logic [2:0]  k;
        logic [5:0]  drop;
        logic [52:0] sig;
        logic [52:0] lowmask;
        logic [7:0]  mag;
        logic [7:0]  code;
        expo    = bits[62:52];
        frac    = bits[51:0];
        neg     = bits[63];
        k       = 3'(expo - EXP_BIAS);
        drop    = 6'd52 - {3'd0, k};
        sig     = {1'b1, frac};
        lowmask = (53'd1 << drop) - 53'd1;
        mag     = 8'(sig >> drop);
        code    = CODE_RAW;
        if (bits == SYSMIS_BITS) begin
            code = CODE_SYSMIS;
        end else if (expo == 11'd0) begin
            code = (frac == 52'd0) ? CODE_ZERO : CODE_RAW;
        end else if (expo >= EXP_BIAS && expo <= EXP_TOP && (sig & lowmask) == 53'd0) begin
            if (neg && mag <= NEG_LIMIT) begin
                code = CODE_ZERO - mag;
            end else if (!neg && mag <= POS_LIMIT) begin
                code = CODE_ZERO + mag;
            end
        end
        return code;
    endfunction

endpackage

// ----- hw/rtl/brc_fifo.sv -----
`timescale 1ns / 1ps

module brc_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  brc_pkg::t_job  i_data,
    output logic           o_full,
    output logic           o_valid,
    output brc_pkg::t_job  o_data,
    input  logic           i_pop
);

    localparam int DEPTH = 2;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    brc_pkg::t_job   r_mem [DEPTH];
    logic [AW-1:0]   r_wp;
    logic [AW-1:0]   r_rp;
    logic [CW-1:0]   r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= AW'((r_wp + AW'(1)) % DEPTH);
            end
            if (i_pop) begin
                r_rp <= AW'((r_rp + AW'(1)) % DEPTH);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) i_push |-> !o_full || i_pop)
        else $error("push into full job queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) i_pop |-> o_valid)
        else $error("pop from empty job queue");

endmodule

// ----- hw/rtl/brc_front.sv -----
`timescale 1ns / 1ps

module brc_front #(
    parameter int BLOCK_WORDS = 128
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_cmd,
    input  logic [63:0]          i_element,
    input  logic                 i_is_string,
    input  logic                 i_ends_case,
    input  logic                 i_enable,
    input  logic                 i_fifo_full,
    output logic                 o_push,
    output brc_pkg::t_job        o_job,
    output brc_pkg::t_raw_wr     o_raw_wr,
    input  brc_pkg::t_bank_free  i_free
);

    localparam int PW = $clog2(BLOCK_WORDS + 1);
    localparam logic [PW-1:0] BW_L = PW'(BLOCK_WORDS);

    logic [7:0]    r_codes [8];
    logic [7:0]    n_codes [8];
    logic [3:0]    r_code_cnt, n_code_cnt;
    logic          r_open, n_open;
    logic [3:0]    r_raw_cnt, n_raw_cnt;
    logic [PW-1:0] r_blk_pos, n_blk_pos;
    logic [30:0]   r_total, n_total;
    logic          r_bank, n_bank;
    logic [1:0]    r_busy, n_busy;

    logic          accept;
    logic          set_busy;
    logic [7:0]    code;
    logic [7:0]    codes_ins [8];
    logic [PW-1:0] pos1;
    logic [3:0]    cnt0, cnt1, raw0;
    logic [63:0]   cw_close, cw_ins;

    assign o_ready = !i_fifo_full && !r_busy[r_bank];
    assign accept  = i_valid && o_ready;

    always_comb begin
        if (i_is_string) begin
            code = (i_element == brc_pkg::SPACES_BITS) ? brc_pkg::CODE_SPACES
                                                       : brc_pkg::CODE_RAW;
        end else begin
            code = brc_pkg::numeric_code(i_element);
        end

        cnt0 = r_open ? r_code_cnt : 4'd0;
        raw0 = r_open ? r_raw_cnt : 4'd0;
        cnt1 = cnt0 + 4'd1;
        if (r_open) begin
            pos1 = r_blk_pos;
        end else begin
            pos1 = ((r_blk_pos >= BW_L) ? PW'(0) : r_blk_pos) + PW'(1);
        end

        codes_ins = r_codes;
        codes_ins[cnt0[2:0]] = code;
        for (int i = 0; i < 8; i++) begin
            cw_close[8*i +: 8] = (4'(i) < r_code_cnt) ? r_codes[i] : 8'd0;
            cw_ins[8*i +: 8]   = (4'(i) < cnt1) ? codes_ins[i] : 8'd0;
        end

        n_codes    = r_codes;
        n_code_cnt = r_code_cnt;
        n_open     = r_open;
        n_raw_cnt  = r_raw_cnt;
        n_blk_pos  = r_blk_pos;
        n_total    = r_total;
        n_bank     = r_bank;
        set_busy   = 1'b0;
        o_push     = 1'b0;
        o_job      = '0;
        o_raw_wr   = '0;

        if (accept) begin
            if (i_cmd) begin
                o_push          = 1'b1;
                o_job.octet     = r_open;
                o_job.cw        = cw_close;
                o_job.nraw      = r_open ? r_raw_cnt : 4'd0;
                o_job.bank      = r_bank;
                o_job.tail      = 1'b1;
                o_job.tail_word = 64'(r_total);
                o_job.tail_cnt  = 1'b1;
                n_open     = 1'b0;
                n_code_cnt = 4'd0;
                n_raw_cnt  = 4'd0;
                n_blk_pos  = '0;
                n_total    = '0;
                set_busy   = r_open;
            end else begin
                if (i_ends_case && r_total != brc_pkg::CASE_MAX) begin
                    n_total = r_total + 31'd1;
                end
                if (!i_enable) begin
                    o_push          = 1'b1;
                    o_job.tail      = 1'b1;
                    o_job.tail_word = i_element;
                end else begin
                    n_codes    = codes_ins;
                    n_open     = 1'b1;
                    n_code_cnt = cnt1;
                    n_raw_cnt  = raw0;
                    n_blk_pos  = pos1;
                    if (code == brc_pkg::CODE_RAW) begin
                        if (pos1 >= BW_L) begin
                            // block full: close octet early, raw word opens next block
                            o_push          = 1'b1;
                            o_job.octet     = 1'b1;
                            o_job.cw        = cw_ins;
                            o_job.nraw      = raw0;
                            o_job.bank      = r_bank;
                            o_job.tail      = 1'b1;
                            o_job.tail_word = i_element;
                            n_blk_pos  = PW'(1);
                            n_open     = 1'b0;
                            n_code_cnt = 4'd0;
                            n_raw_cnt  = 4'd0;
                            set_busy   = 1'b1;
                        end else begin
                            n_blk_pos     = pos1 + PW'(1);
                            o_raw_wr.en   = 1'b1;
                            o_raw_wr.addr = {r_bank, raw0[2:0]};
                            o_raw_wr.data = i_element;
                            n_raw_cnt     = raw0 + 4'd1;
                        end
                    end
                    if (n_open && cnt1 == brc_pkg::OCTET_FULL) begin
                        o_push      = 1'b1;
                        o_job.octet = 1'b1;
                        o_job.cw    = cw_ins;
                        o_job.nraw  = n_raw_cnt;
                        o_job.bank  = r_bank;
                        n_open      = 1'b0;
                        n_code_cnt  = 4'd0;
                        n_raw_cnt   = 4'd0;
                        set_busy    = 1'b1;
                    end
                end
            end
        end

        n_busy = r_busy;
        if (i_free.en) begin
            n_busy[i_free.bank] = 1'b0;
        end
        if (set_busy) begin
            n_busy[r_bank] = 1'b1;
            n_bank         = ~r_bank;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_cnt <= '0;
            r_open     <= 1'b0;
            r_raw_cnt  <= '0;
            r_blk_pos  <= '0;
            r_total    <= '0;
            r_bank     <= 1'b0;
            r_busy     <= '0;
        end else begin
            r_code_cnt <= n_code_cnt;
            r_open     <= n_open;
            r_raw_cnt  <= n_raw_cnt;
            r_blk_pos  <= n_blk_pos;
            r_total    <= n_total;
            r_bank     <= n_bank;
            r_busy     <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_codes <= n_codes;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_raw_wr.en |-> !r_busy[r_bank])
        else $error("raw word written into a bank still draining");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open |-> (r_code_cnt != 4'd0 && r_code_cnt < brc_pkg::OCTET_FULL))
        else $error("open octet with bad code count");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_raw_cnt <= r_code_cnt)
        else $error("more raw words than codes");

endmodule

// ----- hw/rtl/brc_back.sv -----
`timescale 1ns / 1ps

module brc_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_job_valid,
    input  brc_pkg::t_job        i_job,
    output logic                 o_pop,
    input  brc_pkg::t_raw_wr     i_raw_wr,
    output brc_pkg::t_bank_free  o_free,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [63:0]          o_word,
    output logic                 o_is_count,
    output logic                 o_last
);

    logic [63:0]    r_raw [16];
    brc_pkg::t_job  r_job;
    logic           r_active;
    logic [3:0]     r_ph;
    logic           r_o_valid;
    logic [63:0]    r_o_word;
    logic           r_o_cnt;
    logic           r_o_last;

    logic        advance;
    logic        is_final;
    logic        tail_ph;
    logic        load;
    logic [3:0]  final_ph;
    logic [2:0]  rd_idx;
    logic [63:0] word;

    always_comb begin
        advance  = r_active && (!r_o_valid || i_ready);
        final_ph = r_job.tail ? r_job.nraw + 4'd1 : r_job.nraw;
        is_final = (r_ph == final_ph);
        tail_ph  = (r_ph == r_job.nraw + 4'd1);
        rd_idx   = 3'(r_ph - 4'd1);
        if (r_ph == 4'd0) begin
            word = r_job.cw;
        end else if (!tail_ph) begin
            word = r_raw[{r_job.bank, rd_idx}];
        end else begin
            word = r_job.tail_word;
        end
        load        = i_job_valid && (!r_active || (advance && is_final));
        o_pop       = load;
        o_free.en   = advance && is_final && r_job.octet;
        o_free.bank = r_job.bank;
    end

    assign o_valid    = r_o_valid;
    assign o_word     = r_o_word;
    assign o_is_count = r_o_cnt;
    assign o_last     = r_o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
            if (load) begin
                r_active <= 1'b1;
            end else if (advance && is_final) begin
                r_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_raw_wr.en) begin
            r_raw[i_raw_wr.addr] <= i_raw_wr.data;
        end
        if (advance) begin
            r_o_word <= word;
            r_o_cnt  <= tail_ph && r_job.tail_cnt;
            r_o_last <= is_final;
        end
        if (load) begin
            r_job <= i_job;
            r_ph  <= i_job.octet ? 4'd0 : 4'd1;
        end else if (advance && !is_final) begin
            r_ph <= r_ph + 4'd1;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> r_ph <= final_ph)
        else $error("job phase past its final word");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active && !r_job.octet) |-> (r_job.tail && r_job.nraw == 4'd0))
        else $error("job without command word carries raw words");

endmodule

// ----- hw/rtl/bytecode_record_compressor.sv -----
`timescale 1ns / 1ps

// Bytecode record compressor. The front end takes one item per clock and
// classifies it; the back end writes one output word per clock while the
// output is ready, from a two-entry job queue. An item causes zero to nine
// words (a completed octet gives its command word plus up to eight raw
// words), so the output word stream sets the sustained rate. Input stalls
// when the job queue is full or when the raw buffer bank the front end
// fills next is still being read out. Config writes are taken at any time;
// no clearing pass after reset.
module bytecode_record_compressor #(
    parameter int BLOCK_WORDS = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_cmd,
    input  logic [63:0] i_element,
    input  logic        i_is_string,
    input  logic        i_ends_case,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_word,
    output logic        o_is_count,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_compress_enable
);

    logic                 r_compress_en;
    logic                 fifo_full;
    logic                 push;
    logic                 pop;
    logic                 job_valid;
    brc_pkg::t_job        job_in;
    brc_pkg::t_job        job_out;
    brc_pkg::t_raw_wr     raw_wr;
    brc_pkg::t_bank_free  bank_free;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_compress_en <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_compress_en <= i_cfg_compress_enable;
        end
    end

    brc_front #(
        .BLOCK_WORDS(BLOCK_WORDS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_cmd       (i_cmd),
        .i_element   (i_element),
        .i_is_string (i_is_string),
        .i_ends_case (i_ends_case),
        .i_enable    (r_compress_en),
        .i_fifo_full (fifo_full),
        .o_push      (push),
        .o_job       (job_in),
        .o_raw_wr    (raw_wr),
        .i_free      (bank_free)
    );

    brc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (job_in),
        .o_full  (fifo_full),
        .o_valid (job_valid),
        .o_data  (job_out),
        .i_pop   (pop)
    );

    brc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job_out),
        .o_pop       (pop),
        .i_raw_wr    (raw_wr),
        .o_free      (bank_free),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_word      (o_word),
        .o_is_count  (o_is_count),
        .o_last      (o_last)
    );

endmodule
